/* hdl/tac_pkg.sv */
// shared types, widths and arctangent table for the tilt angle pipeline
`default_nettype none

package tac_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STAGES_DEF = 20;

    localparam int DW        = 64;
    localparam int AW        = 30;
    localparam int ANG_FRAC  = 20;
    localparam int WH_W      = AW - ANG_FRAC;
    localparam int SCALE_TOP = 59;
    localparam int GAIN_FRAC = 24;
    localparam int GW        = 26;
    localparam int DEG_W     = 8;

    localparam logic signed [GW-1:0] GAIN_Q = 26'sd27628053;

    localparam logic signed [AW-1:0] ANG_P180 = AW'(180 * (1 << ANG_FRAC));
    localparam logic signed [AW-1:0] ANG_N180 = -ANG_P180;

    localparam logic [DEG_W-1:0]        DEG_LIM  = 8'd90;
    localparam logic signed [DEG_W-1:0] DEG_P90  = 8'sd90;
    localparam logic signed [DEG_W-1:0] DEG_N90  = -8'sd90;
    localparam logic signed [DEG_W-1:0] DEG_ZERO = 8'sd0;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [AW-1:0] ang;
    } t_vec;

    typedef struct packed {
        logic                    ax_zero;
        logic                    ax_pos;
        logic                    ay_zero;
        logic                    ay_pos;
        logic                    az_zero;
        logic                    az_neg;
        logic signed [DW-1:0]    py;
        logic signed [DEG_W-1:0] roll;
    } t_side;

    // atan(2^-i) in degrees with ANG_FRAC fraction bits, rounded
    function automatic logic signed [AW-1:0] tac_atan(input int idx);
        logic signed [AW-1:0] v;
        case (idx)
            0:       v = AW'(47185920);
            1:       v = AW'(27855475);
            2:       v = AW'(14718068);
            3:       v = AW'(7471121);
            4:       v = AW'(3750058);
            5:       v = AW'(1876857);
            6:       v = AW'(938658);
            7:       v = AW'(469357);
            8:       v = AW'(234682);
            9:       v = AW'(117342);
            10:      v = AW'(58671);
            11:      v = AW'(29335);
            12:      v = AW'(14668);
            13:      v = AW'(7334);
            14:      v = AW'(3667);
            15:      v = AW'(1833);
            16:      v = AW'(917);
            17:      v = AW'(458);
            18:      v = AW'(229);
            19:      v = AW'(115);
            20:      v = AW'(57);
            21:      v = AW'(29);
            22:      v = AW'(14);
            23:      v = AW'(7);
            24:      v = AW'(4);
            25:      v = AW'(2);
            26:      v = AW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hdl/tac_prerot.sv */
// quadrant fold cell ahead of each cordic chain
`default_nettype none

module tac_prerot
    import tac_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_vec  i_vec,
    input  t_side i_side,
    output logic  o_valid,
    output t_vec  o_vec,
    output t_side o_side
);

    logic                 r_valid;
    t_vec                 r_vec;
    t_side                r_side;
    t_vec                 n_vec;
    logic signed [DW-1:0] w_x;
    logic signed [DW-1:0] w_y;

    assign w_x = i_vec.x;
    assign w_y = i_vec.y;

    always_comb begin
        n_vec = i_vec;
        if (w_x < 0) begin
            n_vec.x   = -w_x;
            n_vec.y   = -w_y;
            n_vec.ang = (w_y >= 0) ? ANG_P180 : ANG_N180;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec  <= n_vec;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;
    assign o_side  = r_side;

endmodule

`default_nettype wire

/* hdl/tac_cell.sv */
// one cordic vectoring iteration with its pipeline register
`default_nettype none

module tac_cell
    import tac_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_vec  i_vec,
    input  t_side i_side,
    output logic  o_valid,
    output t_vec  o_vec,
    output t_side o_side
);

    localparam logic signed [AW-1:0] ATAN = tac_atan(STAGE);

    logic                 r_valid;
    t_vec                 r_vec;
    t_side                r_side;
    t_vec                 n_vec;
    logic signed [DW-1:0] w_x;
    logic signed [DW-1:0] w_y;
    logic signed [AW-1:0] w_ang;
    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;

    assign w_x   = i_vec.x;
    assign w_y   = i_vec.y;
    assign w_ang = i_vec.ang;
    assign w_dx  = w_y >>> STAGE;
    assign w_dy  = w_x >>> STAGE;

    always_comb begin
        if (w_y >= 0) begin
            n_vec.x   = w_x + w_dx;
            n_vec.y   = w_y - w_dy;
            n_vec.ang = w_ang + ATAN;
        end else begin
            n_vec.x   = w_x - w_dx;
            n_vec.y   = w_y + w_dy;
            n_vec.ang = w_ang - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec  <= n_vec;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;
    assign o_side  = r_side;

endmodule

`default_nettype wire

/* hdl/tilt_angle_from_accel_core.sv */
// roll and pitch in whole degrees from one three-axis accelerometer sample
// a sample passes the input register, the roll row, the pitch row and the output register in that order
// throughput: one transaction per cycle, busy stays low; set by the two cordic cell rows
// each row has one fold cell and CORDIC_STAGES iteration cells, one register per cell
// synchronous active-low reset clears all valid bits, data in flight is dropped
// the receiver cannot stall, every result is shown for exactly one cycle
`default_nettype none

module tilt_angle_from_accel_core
    import tac_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_z,
    output logic                           o_strobe,
    output logic signed [DEG_W-1:0]        o_roll_deg,
    output logic signed [DEG_W-1:0]        o_pitch_deg
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int N      = CORDIC_STAGES;
    localparam int SHIFT  = SCALE_TOP - SW;
    localparam int PSHIFT = SHIFT - GAIN_FRAC;
    localparam int PW     = SW + 1 + GW;
    localparam int LAT    = 2 * N + 4;

    function automatic logic signed [DEG_W-1:0] f_to_deg(input logic signed [AW-1:0] ang);
        logic [AW-1:0]    mag;
        logic [WH_W-1:0]  whole;
        logic [DEG_W-1:0] lim;
        mag   = ang[AW-1] ? $unsigned(-ang) : $unsigned(ang);
        whole = mag[AW-1:ANG_FRAC];
        if (whole > WH_W'(DEG_LIM)) begin
            lim = DEG_LIM;
        end else begin
            lim = whole[DEG_W-1:0];
        end
        return ang[AW-1] ? $signed(-lim) : $signed(lim);
    endfunction

    // input stage
    logic                 w_accept;
    logic signed [SW:0]   w_neg_x;
    logic signed [PW-1:0] n_prod;
    logic signed [PW-1:0] r_prod;
    logic                 r_s1_valid;
    t_vec                 r_s1_vec;
    t_side                r_s1_side;
    t_vec                 n_s1_vec;
    t_side                n_s1_side;
    t_side                w_s1_side;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_neg_x  = -$signed({i_accel_x[SW-1], i_accel_x});
    assign n_prod   = w_neg_x * GAIN_Q;

    always_comb begin
        n_s1_vec.x        = {{(DW-SCALE_TOP){i_accel_z[SW-1]}}, i_accel_z, {SHIFT{1'b0}}};
        n_s1_vec.y        = {{(DW-SCALE_TOP){i_accel_y[SW-1]}}, i_accel_y, {SHIFT{1'b0}}};
        n_s1_vec.ang      = '0;
        n_s1_side.ax_zero = (i_accel_x == '0);
        n_s1_side.ax_pos  = !i_accel_x[SW-1] && (i_accel_x != '0);
        n_s1_side.ay_zero = (i_accel_y == '0);
        n_s1_side.ay_pos  = !i_accel_y[SW-1] && (i_accel_y != '0);
        n_s1_side.az_zero = (i_accel_z == '0);
        n_s1_side.az_neg  = i_accel_z[SW-1];
        n_s1_side.py      = '0;
        n_s1_side.roll    = DEG_ZERO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_vec  <= n_s1_vec;
        r_s1_side <= n_s1_side;
        r_prod    <= n_prod;
    end

    always_comb begin
        w_s1_side    = r_s1_side;
        w_s1_side.py = {{(DW-PW){r_prod[PW-1]}}, r_prod} <<< PSHIFT;
    end

    // roll row
    logic [N:0] w_rvalid;
    t_vec       w_rvec  [N+1];
    t_side      w_rside [N+1];

    tac_prerot u_roll_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_vec   (r_s1_vec),
        .i_side  (w_s1_side),
        .o_valid (w_rvalid[0]),
        .o_vec   (w_rvec[0]),
        .o_side  (w_rside[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_roll
        tac_cell #(.STAGE(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_rvalid[g]),
            .i_vec   (w_rvec[g]),
            .i_side  (w_rside[g]),
            .o_valid (w_rvalid[g+1]),
            .o_vec   (w_rvec[g+1]),
            .o_side  (w_rside[g+1])
        );
    end

    // roll resolution and pitch row input
    t_vec                    w_pin_vec;
    t_side                   w_pin_side;
    logic signed [DEG_W-1:0] w_roll;

    always_comb begin
        if (w_rside[N].ay_zero) begin
            w_roll = w_rside[N].az_neg ? DEG_P90 : DEG_ZERO;
        end else if (w_rside[N].az_zero) begin
            w_roll = w_rside[N].ay_pos ? DEG_P90 : DEG_N90;
        end else begin
            w_roll = f_to_deg(w_rvec[N].ang);
        end
        w_pin_vec.x     = w_rvec[N].x;
        w_pin_vec.y     = w_rside[N].py;
        w_pin_vec.ang   = '0;
        w_pin_side      = w_rside[N];
        w_pin_side.roll = w_roll;
    end

    // pitch row
    logic [N:0] w_pvalid;
    t_vec       w_pvec  [N+1];
    t_side      w_pside [N+1];

    tac_prerot u_pitch_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rvalid[N]),
        .i_vec   (w_pin_vec),
        .i_side  (w_pin_side),
        .o_valid (w_pvalid[0]),
        .o_vec   (w_pvec[0]),
        .o_side  (w_pside[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_pitch
        tac_cell #(.STAGE(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_pvalid[g]),
            .i_vec   (w_pvec[g]),
            .i_side  (w_pside[g]),
            .o_valid (w_pvalid[g+1]),
            .o_vec   (w_pvec[g+1]),
            .o_side  (w_pside[g+1])
        );
    end

    // output stage
    logic                    r_strobe;
    logic signed [DEG_W-1:0] r_roll;
    logic signed [DEG_W-1:0] r_pitch;
    logic signed [DEG_W-1:0] n_pitch;

    always_comb begin
        if (w_pside[N].ax_zero) begin
            n_pitch = DEG_ZERO;
        end else if (w_pside[N].ay_zero && w_pside[N].az_zero) begin
            n_pitch = w_pside[N].ax_pos ? DEG_N90 : DEG_P90;
        end else begin
            n_pitch = f_to_deg(w_pvec[N].ang);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_pvalid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_roll  <= w_pside[N].roll;
        r_pitch <= n_pitch;
    end

    assign o_strobe    = r_strobe;
    assign o_roll_deg  = r_roll;
    assign o_pitch_deg = r_pitch;

`ifndef SYNTHESIS
    a_strobe_follows_transaction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, LAT))
        else $error("result strobe without a matching input transaction");

    a_angles_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_roll_deg >= DEG_N90 && o_roll_deg <= DEG_P90
                      && o_pitch_deg >= DEG_N90 && o_pitch_deg <= DEG_P90))
        else $error("angle outside the clamp range");

    a_magnitude_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rvalid[N] |-> !w_rvec[N].x[DW-1])
        else $error("roll row magnitude went negative");
`endif

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// self-checking testbench for the accelerometer roll and pitch pipeline
`default_nettype none

module testbench;
    import tac_pkg::*;

    localparam int     SW          = SAMPLE_WIDTH_DEF;
    localparam int     STAGES      = CORDIC_STAGES_DEF;
    localparam int     LATENCY     = 2 * STAGES + 4;
    localparam int     FRAC        = 20;
    localparam int     SCALE_SH    = 59 - SW;
    localparam int     GAIN_SH     = SCALE_SH - 24;
    localparam longint CORDIC_GAIN = 27628053;
    localparam int     STALL_LIMIT = 2000;

    typedef logic signed [SW-1:0] sample_t;

    typedef struct packed {
        sample_t                 ax;
        sample_t                 ay;
        sample_t                 az;
        logic signed [DEG_W-1:0] roll;
        logic signed [DEG_W-1:0] pitch;
    } tilt_t;

    typedef struct packed {
        logic signed [63:0] mag;
        logic signed [63:0] ang;
    } vec_res_t;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    start       = 1'b0;
    sample_t                 i_accel_x   = '0;
    sample_t                 i_accel_y   = '0;
    sample_t                 i_accel_z   = '0;
    logic                    busy;
    logic                    o_strobe;
    logic signed [DEG_W-1:0] o_roll_deg;
    logic signed [DEG_W-1:0] o_pitch_deg;

    longint atan_q [32] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7,
        4, 2, 1, 0, 0, 0, 0, 0
    };

    tilt_t pending_tilt [$];
    int    mismatch_count = 0;
    int    gap_pct        = 0;
    int    stall_cycles   = 0;

    tilt_angle_from_accel_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .o_strobe    (o_strobe),
        .o_roll_deg  (o_roll_deg),
        .o_pitch_deg (o_pitch_deg)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic vec_res_t cordic_vector(longint vx, longint vy);
        vec_res_t r;
        longint   ang;
        longint   dx;
        longint   dy;
        int       i;
        ang = 0;
        if (vx < 0) begin
            ang = (vy >= 0) ? (longint'(180) <<< FRAC) : -(longint'(180) <<< FRAC);
            vx  = -vx;
            vy  = -vy;
        end
        for (i = 0; i < STAGES; i++) begin
            dx = vy >>> (i % 32);
            dy = vx >>> (i % 32);
            if (vy >= 0) begin
                vx  = vx + dx;
                vy  = vy - dy;
                ang = ang + atan_q[i % 32];
            end else begin
                vx  = vx - dx;
                vy  = vy + dy;
                ang = ang - atan_q[i % 32];
            end
        end
        r.mag = vx;
        r.ang = ang;
        return r;
    endfunction

    function automatic logic signed [DEG_W-1:0] clamp_deg(longint ang);
        longint d;
        d = (ang < 0) ? -((-ang) >>> FRAC) : (ang >>> FRAC);
        if (d < -90) d = -90;
        if (d > 90) d = 90;
        return d[DEG_W-1:0];
    endfunction

    function automatic tilt_t predict_tilt(sample_t ax, sample_t ay, sample_t az);
        tilt_t    t;
        vec_res_t rv;
        vec_res_t pv;
        longint   x;
        longint   y;
        longint   z;
        longint   py;
        x    = ax;
        y    = ay;
        z    = az;
        t.ax = ax;
        t.ay = ay;
        t.az = az;
        rv   = cordic_vector(z <<< SCALE_SH, y <<< SCALE_SH);
        if (y == 0)
            t.roll = (z >= 0) ? 8'sd0 : 8'sd90;
        else if (z == 0)
            t.roll = (y > 0) ? 8'sd90 : -8'sd90;
        else
            t.roll = clamp_deg(rv.ang);
        if (x == 0) begin
            t.pitch = 8'sd0;
        end else if (y == 0 && z == 0) begin
            t.pitch = (x > 0) ? -8'sd90 : 8'sd90;
        end else begin
            py      = (-x) * CORDIC_GAIN * (longint'(1) <<< GAIN_SH);
            pv      = cordic_vector(rv.mag, py);
            t.pitch = clamp_deg(pv.ang);
        end
        return t;
    endfunction

    function automatic sample_t rand_axis();
        case ($urandom_range(15))
            0:       return '0;
            1:       return {1'b1, {(SW-1){1'b0}}};
            2:       return {1'b0, {(SW-1){1'b1}}};
            3:       return sample_t'(int'($urandom_range(64)) - 32);
            4:       return sample_t'(int'($urandom_range(4096)) - 2048);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    task automatic send_tilt(input sample_t ax, input sample_t ay, input sample_t az);
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start     <= 1'b1;
        i_accel_x <= ax;
        i_accel_y <= ay;
        i_accel_z <= az;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_tilt.push_back(predict_tilt(ax, ay, az));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_tilt.size() > 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        tilt_t want;
        if (i_rst_n && o_strobe) begin
            if (pending_tilt.size() == 0) begin
                flag_mismatch($sformatf("result with nothing pending: roll %0d pitch %0d",
                                        o_roll_deg, o_pitch_deg));
            end else begin
                want = pending_tilt.pop_front();
                if (o_roll_deg !== want.roll)
                    flag_mismatch($sformatf("roll x=%0d y=%0d z=%0d expected %0d got %0d",
                                            want.ax, want.ay, want.az, want.roll, o_roll_deg));
                if (o_pitch_deg !== want.pitch)
                    flag_mismatch($sformatf("pitch x=%0d y=%0d z=%0d expected %0d got %0d",
                                            want.ax, want.ay, want.az, want.pitch, o_pitch_deg));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic test_special_cases();
        gap_pct = 0;
        send_tilt(0, 0, 0);
        send_tilt(0, 0, 100);
        send_tilt(0, 0, -100);
        send_tilt(0, 100, 0);
        send_tilt(0, -100, 0);
        send_tilt(100, 0, 0);
        send_tilt(-100, 0, 0);
        send_tilt(-32768, 0, 0);
        send_tilt(32767, 0, 0);
        send_tilt(1, 1, -32768);
        send_tilt(1, -1, -32768);
        send_tilt(32767, 1, 0);
    endtask

    task automatic test_extremes();
        gap_pct = 0;
        send_tilt(-32768, -32768, -32768);
        send_tilt(32767, 32767, 32767);
        send_tilt(32767, -32768, 32767);
        send_tilt(-32768, 32767, -32768);
        send_tilt(0, 1000, 1000);
        send_tilt(1000, 0, 1000);
        send_tilt(-1000, 1000, -1000);
        send_tilt(500, 866, -500);
        send_tilt(-1, -1, -1);
        send_tilt(1, 1, 1);
    endtask

    task automatic test_random(input int count, input int pct);
        gap_pct = pct;
        repeat (count) send_tilt(rand_axis(), rand_axis(), rand_axis());
    endtask

    task automatic test_drain_pause();
        gap_pct = 0;
        repeat (10) send_tilt(rand_axis(), rand_axis(), rand_axis());
        wait_drained();
        repeat (10) send_tilt(rand_axis(), rand_axis(), rand_axis());
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_special_cases();
        test_extremes();
        test_random(100, 0);
        test_random(100, 49);
        test_random(100, 11);
        test_drain_pause();
        test_random(80, 0);
        wait_drained();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (mismatch_count == 0 && pending_tilt.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hdl/tac_pkg.sv
hdl/tac_prerot.sv
hdl/tac_cell.sv
hdl/tilt_angle_from_accel_core.sv
tb/sv/testbench.sv
